FILE: src/isl_pkg.sv
// shared constants, types and codes of the indexed shift list
package isl_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 5;
    localparam int VAL_W      = 32;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_RANGE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_BAD   = 2'd1,
        STS_FULL  = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] pos;
        t_word            word;
    } t_cell_ctl;

endpackage

FILE: src/isl_if.sv
// command and result channels of the indexed shift list
interface isl_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     cmd;
    logic [isl_pkg::POS_W-1:0]      position;
    logic [isl_pkg::POS_W-1:0]      range_end;
    logic signed [isl_pkg::VAL_W-1:0] value;

    modport source (output valid, output cmd, output position, output range_end,
                    output value, input ready);
    modport sink   (input valid, input cmd, input position, input range_end,
                    input value, output ready);
endinterface

interface isl_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [isl_pkg::VAL_W-1:0] read_value;
    logic [4:0]                       count;
    logic [1:0]                       status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

FILE: src/isl_cell.sv
// one storage cell of the shift chain
module isl_cell (
    input  logic                      i_clk,
    input  logic [isl_pkg::IDX_W-1:0] i_index,
    input  isl_pkg::t_cell_ctl        i_ctl,
    input  isl_pkg::t_word            i_prev,
    input  isl_pkg::t_word            i_next,
    output isl_pkg::t_word            o_word
);

    isl_pkg::t_word r_word;
    isl_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            isl_pkg::CELL_INS: begin
                if (i_index > i_ctl.pos) begin
                    n_word = i_prev;
                end else if (i_index == i_ctl.pos) begin
                    n_word = i_ctl.word;
                end
            end
            isl_pkg::CELL_DEL: begin
                if (i_index >= i_ctl.pos) begin
                    n_word = i_next;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: src/isl_ctrl.sv
// command checking, entry count, shift sequencing and result register
module isl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    isl_cmd_if.sink            i_cmd,
    isl_res_if.source          o_res,
    input  isl_pkg::t_word     i_read_word,
    output isl_pkg::t_cell_ctl o_cell_ctl
);

    isl_pkg::t_state r_state, n_state;
    logic [isl_pkg::CNT_W-1:0] r_count;
    logic [isl_pkg::POS_W-1:0] r_left;
    logic [isl_pkg::IDX_W-1:0] r_pos;

    logic                             r_out_valid;
    logic signed [isl_pkg::VAL_W-1:0] r_read_value;
    logic [4:0]                       r_out_count;
    isl_pkg::t_status                 r_status;

    logic                      accept;
    logic                      ready;
    logic [isl_pkg::CMP_W-1:0] pos_c, end_c, cnt_c;
    logic [isl_pkg::POS_W-1:0] gap;
    isl_pkg::t_status          chk_status;
    isl_pkg::t_cell_op         chk_op;
    logic [isl_pkg::CNT_W-1:0] chk_count;
    logic [isl_pkg::VAL_W-1:0] chk_read;
    logic                      chk_multi;

    assign accept = i_cmd.valid && ready;
    assign pos_c  = isl_pkg::CMP_W'(i_cmd.position);
    assign end_c  = isl_pkg::CMP_W'(i_cmd.range_end);
    assign cnt_c  = isl_pkg::CMP_W'(r_count);
    assign gap    = i_cmd.range_end - i_cmd.position;

    // command checks against the current entry count
    always_comb begin
        chk_status = isl_pkg::STS_OK;
        chk_op     = isl_pkg::CELL_HOLD;
        chk_count  = r_count;
        chk_read   = '0;
        chk_multi  = 1'b0;
        case (isl_pkg::t_cmd'(i_cmd.cmd))
            isl_pkg::CMD_INSERT: begin
                if (cnt_c >= isl_pkg::CMP_W'(isl_pkg::DEPTH)) begin
                    chk_status = isl_pkg::STS_FULL;
                end else if (pos_c > cnt_c) begin
                    chk_status = isl_pkg::STS_BAD;
                end else begin
                    chk_op    = isl_pkg::CELL_INS;
                    chk_count = r_count + 1'b1;
                end
            end
            isl_pkg::CMD_ERASE: begin
                if (r_count == '0) begin
                    chk_status = isl_pkg::STS_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    chk_status = isl_pkg::STS_BAD;
                end else begin
                    chk_op    = isl_pkg::CELL_DEL;
                    chk_count = r_count - 1'b1;
                end
            end
            isl_pkg::CMD_RANGE: begin
                if (pos_c > end_c || end_c > cnt_c) begin
                    chk_status = isl_pkg::STS_BAD;
                end else if (gap != '0) begin
                    chk_op    = isl_pkg::CELL_DEL;
                    chk_count = isl_pkg::CNT_W'(cnt_c - isl_pkg::CMP_W'(gap));
                    chk_multi = (gap != isl_pkg::POS_W'(1));
                end
            end
            isl_pkg::CMD_READ: begin
                if (r_count == '0) begin
                    chk_status = isl_pkg::STS_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    chk_status = isl_pkg::STS_BAD;
                end else begin
                    chk_read = isl_pkg::VAL_W'(i_read_word);
                end
            end
            isl_pkg::CMD_CLEAR: begin
                chk_count = '0;
            end
            default: chk_status = isl_pkg::STS_BAD;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isl_pkg::ST_IDLE:  if (accept && chk_multi) n_state = isl_pkg::ST_SHIFT;
            isl_pkg::ST_SHIFT: if (r_left == isl_pkg::POS_W'(1)) n_state = isl_pkg::ST_IDLE;
            default:           n_state = isl_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ready      = 1'b0;
        o_cell_ctl = '{op: isl_pkg::CELL_HOLD, pos: isl_pkg::IDX_W'(i_cmd.position),
                       word: isl_pkg::t_word'(unsigned'(i_cmd.value))};
        unique case (r_state)
            isl_pkg::ST_IDLE: begin
                ready = !r_out_valid || o_res.ready;
                if (accept) o_cell_ctl.op = chk_op;
            end
            isl_pkg::ST_SHIFT: begin
                o_cell_ctl.op  = isl_pkg::CELL_DEL;
                o_cell_ctl.pos = r_pos;
            end
            default: ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isl_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count     <= chk_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos        <= isl_pkg::IDX_W'(i_cmd.position);
            r_left       <= gap - 1'b1;
            r_read_value <= signed'(chk_read);
            r_out_count  <= 5'(chk_count);
            r_status     <= chk_status;
        end else if (r_state == isl_pkg::ST_SHIFT) begin
            r_left <= r_left - 1'b1;
        end
    end

    assign i_cmd.ready      = ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.read_value = r_read_value;
    assign o_res.count      = r_out_count;
    assign o_res.status     = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        isl_pkg::CMP_W'(r_count) <= isl_pkg::CMP_W'(isl_pkg::DEPTH))
        else $error("entry count above depth");

    a_shift_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == isl_pkg::ST_SHIFT |-> !i_cmd.ready && r_left != '0)
        else $error("command taken during range shift");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.cmd == isl_pkg::CMD_INSERT && chk_status == isl_pkg::STS_OK
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_res.valid && o_res.count == 5'(r_count))
        else $error("result count differs from entry count");

endmodule

FILE: src/indexed_shift_list.sv
// top level of the indexed shift list: command checker and chain of storage cells
// The list is a row of DEPTH cells, each holding one word; on every cycle each cell
// either keeps its word, takes its lower neighbor's word (insert, shifting later
// entries up), takes its upper neighbor's word (erase, shifting down), or loads the
// inserted word. Insert, erase one, read, clear and every rejected command leave the
// controller idle and are accepted one per clock while the output register is free.
// Erase range of n entries shifts the chain down one cell per cycle, n shifts in all
// (none if empty); its result is issued at once, and the next command is accepted
// after the n-th shift. Results sit in a single output register: a new command is
// taken only while that register is empty or its result beat leaves in the same
// cycle, so a stalled receiver stalls the command side. Status codes: ok, bad
// position or range (also unknown commands), list full on insert, list empty on
// erase one or read. Clear only zeroes the entry count; stored words stay.
module indexed_shift_list (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isl_cmd_if.sink   i_cmd,
    isl_res_if.source o_res
);

    // cell words and the broadcast shift control
    isl_pkg::t_word     words [isl_pkg::DEPTH];
    isl_pkg::t_cell_ctl cell_ctl;
    isl_pkg::t_word     read_word;

    // read tap at the commanded position
    assign read_word = words[isl_pkg::IDX_W'(i_cmd.position)];

    isl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .i_read_word (read_word),
        .o_cell_ctl  (cell_ctl)
    );

    // the chain: each cell sees both neighbors
    for (genvar gi = 0; gi < isl_pkg::DEPTH; gi++) begin : g_cell
        isl_pkg::t_word prev_word;
        isl_pkg::t_word next_word;

        // the bottom cell never takes from below
        if (gi == 0) begin : g_bottom
            assign prev_word = '0;
        end else begin : g_lower
            assign prev_word = words[gi-1];
        end

        // the top cell refills from itself, an unused slot after erase
        if (gi == isl_pkg::DEPTH - 1) begin : g_top
            assign next_word = words[gi];
        end else begin : g_upper
            assign next_word = words[gi+1];
        end

        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (isl_pkg::IDX_W'(gi)),
            .i_ctl   (cell_ctl),
            .i_prev  (prev_word),
            .i_next  (next_word),
            .o_word  (words[gi])
        );
    end

endmodule

FILE: tb/tb_indexed_shift_list.sv
// self-checking testbench of the indexed shift list: directed and random commands, scoreboard
`timescale 1ns / 100ps

module tb_indexed_shift_list;

    // command codes above clear are undefined and must be rejected
    localparam int CMD_CODES    = 8;

    // random part: length, quiet tail and receiver hold-off
    localparam int ITEM_TARGET  = 625;
    localparam int CALM_ITEMS   = 80;
    localparam int HOLD_CYCLES  = 60;

    // longest erase range is one shift per entry, plus margin for the output register
    localparam int SETTLE_CYCLES = isl_pkg::DEPTH + 8;

    // kinds of random segment
    localparam int MODE_GROW    = 0;
    localparam int MODE_SHRINK  = 1;
    localparam int MODE_MIXED   = 2;
    localparam int MODE_NOISE   = 3;

    localparam logic signed [isl_pkg::VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [isl_pkg::VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

    // one command beat as the sender offers it
    typedef struct {
        logic [2:0]                       cmd;
        logic [isl_pkg::POS_W-1:0]        position;
        logic [isl_pkg::POS_W-1:0]        range_end;
        logic signed [isl_pkg::VAL_W-1:0] value;
    } t_list_cmd;

    // one result beat, expected or observed
    typedef struct {
        logic signed [isl_pkg::VAL_W-1:0] read_value;
        logic [4:0]                       count;
        logic [1:0]                       status;
    } t_list_res;

    // shadow copy of the list; every accepted command is applied here and its
    // result queued, every result beat is checked against the oldest one
    class shift_list_scoreboard;
        isl_pkg::t_word cells[isl_pkg::DEPTH];
        int unsigned    fill;
        t_list_res      expected_results[$];
        int unsigned    errors;
        int unsigned    commands_seen;
        int unsigned    results_seen;
        int unsigned    status_hits[4];
        int unsigned    deepest_fill;

        function void apply_command(t_list_cmd c);
            t_list_res   r;
            int unsigned gap;
            r.read_value = '0;
            r.status     = isl_pkg::STS_OK;
            case (c.cmd)
                isl_pkg::CMD_INSERT: begin
                    if (fill >= isl_pkg::DEPTH) begin
                        r.status = isl_pkg::STS_FULL;
                    end else if (c.position > fill) begin
                        r.status = isl_pkg::STS_BAD;
                    end else begin
                        for (int i = fill; i > c.position; i--) cells[i] = cells[i-1];
                        cells[c.position] = isl_pkg::t_word'(c.value);
                        fill++;
                    end
                end
                isl_pkg::CMD_ERASE: begin
                    if (fill == 0) begin
                        r.status = isl_pkg::STS_EMPTY;
                    end else if (c.position >= fill) begin
                        r.status = isl_pkg::STS_BAD;
                    end else begin
                        for (int i = c.position; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                isl_pkg::CMD_RANGE: begin
                    if (c.position > c.range_end || c.range_end > fill) begin
                        r.status = isl_pkg::STS_BAD;
                    end else begin
                        gap = c.range_end - c.position;
                        for (int i = c.position; i + gap < fill; i++) cells[i] = cells[i+gap];
                        fill -= gap;
                    end
                end
                isl_pkg::CMD_READ: begin
                    if (fill == 0) begin
                        r.status = isl_pkg::STS_EMPTY;
                    end else if (c.position >= fill) begin
                        r.status = isl_pkg::STS_BAD;
                    end else begin
                        r.read_value = cells[c.position];
                    end
                end
                isl_pkg::CMD_CLEAR: fill = 0;
                default:            r.status = isl_pkg::STS_BAD;
            endcase
            r.count = 5'(fill);
            expected_results = {expected_results, r};
            commands_seen++;
            status_hits[r.status]++;
            if (fill > deepest_fill) deepest_fill = fill;
        endfunction

        function void check_result(t_list_res got);
            t_list_res want;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result beat with no command outstanding");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int unsigned pending_count();
            return expected_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    isl_cmd_if cmd_bus ();
    isl_res_if res_bus ();

    shift_list_scoreboard sb;

    // quiet tail: neither side idles
    bit          calm         = 1'b0;
    // sender asks the receiver for one long hold-off
    bit          hold_off_req = 1'b0;
    int unsigned holds_done   = 0;

    indexed_shift_list u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // offer one beat and hold it until the block takes it; returns at the
    // accepting edge with valid still high
    task automatic send_command(input t_list_cmd c);
        cmd_bus.valid     <= 1'b1;
        cmd_bus.cmd       <= c.cmd;
        cmd_bus.position  <= c.position;
        cmd_bus.range_end <= c.range_end;
        cmd_bus.value     <= c.value;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        sb.apply_command(c);
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [isl_pkg::POS_W-1:0] position,
                         input logic [isl_pkg::POS_W-1:0] range_end,
                         input logic signed [isl_pkg::VAL_W-1:0] value);
        t_list_cmd c;
        c.cmd       = cmd;
        c.position  = position;
        c.range_end = range_end;
        c.value     = value;
        send_command(c);
    endtask

    // sender goes quiet until every outstanding result has come back
    task automatic wait_results_drained();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    // random command shaped by the current fill: mostly legal positions so the
    // list really grows, shrinks and hits full, with a share of wild fields
    function automatic t_list_cmd random_command(input int mode, input int unsigned fill);
        t_list_cmd c;
        int        roll;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       c.value = WORD_MAX;
                1:       c.value = WORD_MIN;
                2:       c.value = '0;
                default: c.value = '1;
            endcase
        end else begin
            c.value = $urandom;
        end

        if (mode == MODE_NOISE) begin
            c.cmd       = 3'($urandom_range(0, CMD_CODES - 1));
            c.position  = isl_pkg::POS_W'($urandom);
            c.range_end = isl_pkg::POS_W'($urandom);
            return c;
        end

        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
                c.cmd = roll < 60 ? isl_pkg::CMD_INSERT : roll < 70 ? isl_pkg::CMD_ERASE :
                        roll < 75 ? isl_pkg::CMD_RANGE  : roll < 99 ? isl_pkg::CMD_READ  :
                        isl_pkg::CMD_CLEAR;
            MODE_SHRINK:
                c.cmd = roll < 15 ? isl_pkg::CMD_INSERT : roll < 55 ? isl_pkg::CMD_ERASE :
                        roll < 75 ? isl_pkg::CMD_RANGE  : roll < 99 ? isl_pkg::CMD_READ  :
                        isl_pkg::CMD_CLEAR;
            default: begin
                if (roll < 35)      c.cmd = isl_pkg::CMD_INSERT;
                else if (roll < 60) c.cmd = isl_pkg::CMD_ERASE;
                else if (roll < 70) c.cmd = isl_pkg::CMD_RANGE;
                else if (roll < 94) c.cmd = isl_pkg::CMD_READ;
                else if (roll < 97) c.cmd = isl_pkg::CMD_CLEAR;
                else c.cmd = 3'($urandom_range(int'(isl_pkg::CMD_CLEAR) + 1, CMD_CODES - 1));
            end
        endcase

        if ($urandom_range(0, 99) < 12) begin
            // out-of-bounds and odd ranges
            c.position  = isl_pkg::POS_W'($urandom);
            c.range_end = isl_pkg::POS_W'($urandom);
        end else begin
            c.range_end = isl_pkg::POS_W'($urandom);
            case (c.cmd)
                isl_pkg::CMD_INSERT: c.position = isl_pkg::POS_W'($urandom_range(0, fill));
                isl_pkg::CMD_RANGE: begin
                    c.position  = isl_pkg::POS_W'($urandom_range(0, fill));
                    c.range_end = isl_pkg::POS_W'($urandom_range(c.position, fill));
                end
                default: c.position = (fill == 0) ? '0 :
                                      isl_pkg::POS_W'($urandom_range(0, fill - 1));
            endcase
        end
        return c;
    endfunction

    // result side: random stalls, one long hold-off on request, none in the tail
    initial begin
        res_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                // long hold-off so the output register fills and the block stalls its input
                hold_off_req = 1'b0;
                holds_done++;
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // results are sampled at the edge, before the block's registers move
    always @(posedge i_clk) begin : result_monitor
        t_list_res got;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            got.read_value = res_bus.read_value;
            got.count      = res_bus.count;
            got.status     = res_bus.status;
            sb.check_result(got);
        end
    end

    initial begin
        t_list_cmd   c;
        int unsigned sent;
        int          seg;
        int          seg_len;
        int          mode;
        int          idle_pct;
        int          pick;

        sb = new();
        cmd_bus.valid     <= 1'b0;
        cmd_bus.cmd       <= isl_pkg::CMD_CLEAR;
        cmd_bus.position  <= '0;
        cmd_bus.range_end <= '0;
        cmd_bus.value     <= '0;
        i_rst_n           <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list first
        issue(isl_pkg::CMD_READ,   0, 0, 0);          // read on empty list
        issue(isl_pkg::CMD_ERASE,  0, 0, 0);          // erase one on empty list
        issue(isl_pkg::CMD_RANGE,  0, 0, 0);          // empty range on empty list is fine
        issue(isl_pkg::CMD_INSERT, 1, 0, 5);          // insert past the end
        issue(isl_pkg::CMD_INSERT, 0, 0, WORD_MAX);
        issue(isl_pkg::CMD_INSERT, 1, 0, WORD_MIN);   // position equal to count appends
        issue(isl_pkg::CMD_INSERT, 0, 0, '1);         // insert at the front shifts all up
        issue(isl_pkg::CMD_INSERT, 3, 0, '0);
        issue(isl_pkg::CMD_INSERT, 5, 0, 9);          // beyond count
        issue(isl_pkg::CMD_READ,   0, 0, 0);
        issue(isl_pkg::CMD_READ,   1, 0, 0);
        issue(isl_pkg::CMD_READ,   3, 0, 0);
        issue(isl_pkg::CMD_READ,   4, 0, 0);          // read at count
        issue(isl_pkg::CMD_READ,   '1, '1, 0);        // position at its field maximum
        issue(isl_pkg::CMD_ERASE,  4, 0, 0);          // erase at count
        issue(isl_pkg::CMD_RANGE,  3, 1, 0);          // start above end
        issue(isl_pkg::CMD_RANGE,  0, 5, 0);          // end past count
        issue(isl_pkg::CMD_RANGE,  2, 2, 0);          // empty range on a filled list
        issue(isl_pkg::CMD_ERASE,  1, 0, 0);
        issue(isl_pkg::CMD_RANGE,  0, 2, 0);          // two entries shifted out
        issue(isl_pkg::CMD_READ,   0, 0, 0);
        for (int u = int'(isl_pkg::CMD_CLEAR) + 1; u < CMD_CODES; u++)
            issue(3'(u), isl_pkg::POS_W'($urandom), isl_pkg::POS_W'($urandom),
                  $urandom);                          // undefined codes
        issue(isl_pkg::CMD_CLEAR,  0, 0, 0);
        issue(isl_pkg::CMD_READ,   0, 0, 0);          // cleared list reads as empty

        // random: segments of one flavor each; the first one grows the list
        sent = 0;
        seg  = 0;
        while (sent < ITEM_TARGET) begin
            if (seg == 0) begin
                mode = MODE_GROW;
            end else begin
                pick = $urandom_range(0, 9);
                mode = pick < 3 ? MODE_GROW : pick < 6 ? MODE_SHRINK :
                       pick < 9 ? MODE_MIXED : MODE_NOISE;
            end
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            seg_len  = $urandom_range(15, 50);

            if (seg == 2 || seg == 7) hold_off_req = 1'b1;
            if (seg == 4 || seg == 9) wait_results_drained();

            for (int k = 0; k < seg_len && sent < ITEM_TARGET; k++) begin
                calm = (sent >= ITEM_TARGET - CALM_ITEMS);
                c    = random_command(mode, sb.fill);
                send_command(c);
                sent++;
                if (!calm && $urandom_range(0, 99) < idle_pct) begin
                    cmd_bus.valid <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                end
            end
            seg++;
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d commands, %0d result beats, %0d long receiver hold-offs",
                 sb.commands_seen, sb.results_seen, holds_done);
        $display("status mix ok/bad/full/empty %0d/%0d/%0d/%0d, deepest fill %0d of %0d",
                 sb.status_hits[isl_pkg::STS_OK], sb.status_hits[isl_pkg::STS_BAD],
                 sb.status_hits[isl_pkg::STS_FULL], sb.status_hits[isl_pkg::STS_EMPTY],
                 sb.deepest_fill, isl_pkg::DEPTH);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/isl_pkg.sv
src/isl_if.sv
src/isl_cell.sv
src/isl_ctrl.sv
src/indexed_shift_list.sv
tb/tb_indexed_shift_list.sv
